>>> sv/nwom_pkg.sv
// nwom_pkg: shared constants and table functions for nth_weekday_of_month
// month tables, calendar reference, reciprocal for constant division by 25
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package nwom_pkg;

	// default and supported year width
	localparam int YEAR_W_DEF = 12;

	// config port geometry
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_TARGET_MONTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OCCURRENCE     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_WEEKDAY = 2'd2;

	// calendar reference: 1 january 1850 was a tuesday
	localparam int BASE_YEAR    = 1850;
	localparam int BASE_WEEKDAY = 2;
	localparam int BASE_LEAPS   = (BASE_YEAR - 1) / 4 - (BASE_YEAR - 1) / 100
		+ (BASE_YEAR - 1) / 400;
	// weekday of jan 1 is (year + leaps_upto(year-1) + JAN_FIX) mod 7
	localparam int JAN_FIX = (BASE_WEEKDAY + 7 * (BASE_YEAR + BASE_LEAPS)
		- BASE_YEAR - BASE_LEAPS) % 7;

	// x / 25 as (x * RECIP_25) >> RECIP_SHIFT, exact for x below 43690
	localparam int RECIP_25    = 20972;
	localparam int RECIP_W     = 15;
	localparam int RECIP_SHIFT = 19;

	// width of the operand folded modulo 7
	localparam int MOD_IN_W = 18;

	// month length in a common year, 0 for codes that are no month
	function automatic logic [4:0] month_len(input logic [3:0] mo);
		logic [4:0] len;
		case (mo)
			4'd1:    len = 5'd31;
			4'd2:    len = 5'd28;
			4'd3:    len = 5'd31;
			4'd4:    len = 5'd30;
			4'd5:    len = 5'd31;
			4'd6:    len = 5'd30;
			4'd7:    len = 5'd31;
			4'd8:    len = 5'd31;
			4'd9:    len = 5'd30;
			4'd10:   len = 5'd31;
			4'd11:   len = 5'd30;
			4'd12:   len = 5'd31;
			default: len = 5'd0;
		endcase
		return len;
	endfunction

	// days before the month in a common year, modulo 7
	function automatic logic [2:0] month_off(input logic [3:0] mo);
		logic [2:0] off;
		case (mo)
			4'd1:    off = 3'd0;
			4'd2:    off = 3'd3;
			4'd3:    off = 3'd3;
			4'd4:    off = 3'd6;
			4'd5:    off = 3'd1;
			4'd6:    off = 3'd4;
			4'd7:    off = 3'd6;
			4'd8:    off = 3'd2;
			4'd9:    off = 3'd5;
			4'd10:   off = 3'd0;
			4'd11:   off = 3'd3;
			4'd12:   off = 3'd5;
			default: off = 3'd0;
		endcase
		return off;
	endfunction

	// modulo 7 by summing octal digits (8 is 1 mod 7)
	function automatic logic [2:0] mod7(input logic [MOD_IN_W-1:0] x);
		logic [5:0] dsum;
		logic [3:0] fold;
		dsum = 6'd0;
		for (int i = 0; i < MOD_IN_W / 3; i++) begin
			dsum = dsum + 6'(x[3*i +: 3]);
		end
		fold = 4'(dsum[5:3]) + 4'(dsum[2:0]);
		if (fold >= 4'd7) begin
			fold = fold - 4'd7;
		end
		return fold[2:0];
	endfunction

endpackage

`default_nettype wire

>>> sv/nth_weekday_of_month.sv
// nth_weekday_of_month: five-stage pipeline giving the day of the n-th weekday in a month
// depends on nwom_pkg for month tables, calendar reference and modulo helpers
`timescale 1ns / 1ps
`default_nettype none

// Accepts one year every clock cycle (busy stays low). One done beat per
// accepted year, in order. Each year passes the five register stages:
// leap-count products, leap count, january weekday, month weekday, final
// compare. The receiver cannot stall, so each result is valid for exactly
// the one cycle that done is high. Configuration (month, occurrence,
// weekday) is written through wr_en / wr_index / wr_data by the user only
// while no year is in flight; the block does not enforce this. A month
// outside 1..12 or occurrence 0 yields day_of_month 0 with not_found set.
module nth_weekday_of_month
	import nwom_pkg::*;
#(
	parameter int YEAR_WIDTH = YEAR_W_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// config write port
	input  wire logic                  wr_en,
	input  wire logic [CFG_IDX_W-1:0]  wr_index,
	input  wire logic [CFG_DATA_W-1:0] wr_data,
	// command side
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [YEAR_WIDTH-1:0] query_year,
	// result side
	output logic                       done,
	output logic [YEAR_WIDTH-1:0]      result_year,
	output logic [4:0]                 day_of_month,
	output logic                       not_found
);

	localparam int QW = YEAR_WIDTH - 2;          // year / 4
	localparam int HW = QW - 4;                  // year / 100
	localparam int PW = QW + RECIP_W;            // reciprocal product
	localparam logic [PW-1:0] RECIP = PW'(RECIP_25);
	localparam logic [YEAR_WIDTH-1:0] BASE_Y = YEAR_WIDTH'(BASE_YEAR);

	// config registers
	logic [3:0] target_month_q;
	logic [2:0] occurrence_q;
	logic [2:0] target_weekday_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_month_q   <= 4'd1;
			occurrence_q     <= 3'd1;
			target_weekday_q <= 3'd1;
		end else if (wr_en) begin
			case (wr_index)
				REG_TARGET_MONTH:   target_month_q   <= wr_data[3:0];
				REG_OCCURRENCE:     occurrence_q     <= wr_data[2:0];
				REG_TARGET_WEEKDAY: target_weekday_q <= wr_data[2:0];
				default: ;
			endcase
		end
	end

	// every cycle takes a beat
	assign busy = 1'b0;

	logic in_beat;
	assign in_beat = start && !busy;

	// valid bits
	logic valid_s1, valid_s2, valid_s3, valid_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_s1 <= in_beat;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			done     <= valid_s4;
		end
	end

	// stage 1: year/4 of year and year-1, times reciprocal of 25
	logic [YEAR_WIDTH-1:0] year_m1;
	logic [QW-1:0]         q4c, q4p;
	logic [YEAR_WIDTH-1:0] year_s1;
	logic [QW-1:0]         q4c_s1, q4p_s1;
	logic [PW-1:0]         prodc_s1, prodp_s1;

	assign year_m1 = query_year - YEAR_WIDTH'(1);
	assign q4c     = query_year[YEAR_WIDTH-1:2];
	assign q4p     = year_m1[YEAR_WIDTH-1:2];

	always_ff @(posedge clk) begin
		if (in_beat) begin
			year_s1  <= query_year;
			q4c_s1   <= q4c;
			q4p_s1   <= q4p;
			prodc_s1 <= PW'(q4c) * RECIP;
			prodp_s1 <= PW'(q4p) * RECIP;
		end
	end

	// stage 2: leap flag of the year, leap count up to the year before
	logic [HW-1:0]         q100c, q100p;
	logic [QW-1:0]         mul25c, leaps;
	logic                  leap, late;
	logic [YEAR_WIDTH-1:0] year_s2;
	logic [QW-1:0]         leaps_s2;
	logic                  leap_s2, late_s2;

	assign q100c  = prodc_s1[RECIP_SHIFT +: HW];
	assign q100p  = prodp_s1[RECIP_SHIFT +: HW];
	assign mul25c = (QW'(q100c) << 4) + (QW'(q100c) << 3) + QW'(q100c);
	// divisible by 4, and not by 100 unless by 400
	assign leap   = (year_s1[1:0] == 2'b00)
		&& ((q4c_s1 != mul25c) || (q100c[1:0] == 2'b00));
	assign leaps  = q4p_s1 - QW'(q100p) + QW'(q100p >> 2);
	assign late   = year_s1 > BASE_Y;

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			year_s2  <= year_s1;
			leaps_s2 <= leaps;
			leap_s2  <= leap;
			late_s2  <= late;
		end
	end

	// stage 3: weekday of january 1
	logic [MOD_IN_W-1:0]   jan_sum;
	logic [2:0]            jan_wd;
	logic [YEAR_WIDTH-1:0] year_s3;
	logic [2:0]            jan_s3;
	logic                  leap_s3;

	assign jan_sum = MOD_IN_W'(year_s2) + MOD_IN_W'(leaps_s2) + MOD_IN_W'(JAN_FIX);
	assign jan_wd  = late_s2 ? mod7(jan_sum) : 3'(BASE_WEEKDAY);

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			year_s3 <= year_s2;
			jan_s3  <= jan_wd;
			leap_s3 <= leap_s2;
		end
	end

	// stage 4: weekday of the month's first day, first matching date, month length
	logic [3:0]            wd_sum, wd_mod, wd_diff, wd_gap;
	logic [2:0]            first_day;
	logic [4:0]            mlen;
	logic                  cfg_ok;
	logic [YEAR_WIDTH-1:0] year_s4;
	logic [2:0]            first_s4;
	logic [4:0]            len_s4;
	logic                  ok_s4;

	always_comb begin
		wd_sum = 4'(jan_s3) + 4'(month_off(target_month_q))
			+ 4'(leap_s3 && (target_month_q >= 4'd3));
		wd_mod = (wd_sum >= 4'd7) ? (wd_sum - 4'd7) : wd_sum;
		// sunday is 7
		if (wd_mod == 4'd0) begin
			wd_mod = 4'd7;
		end
		wd_diff   = 4'(target_weekday_q) + 4'd7 - wd_mod;
		wd_gap    = (wd_diff >= 4'd7) ? (wd_diff - 4'd7) : wd_diff;
		first_day = wd_gap[2:0] + 3'd1;
		mlen      = month_len(target_month_q)
			+ 5'(leap_s3 && (target_month_q == 4'd2));
		cfg_ok    = (target_month_q >= 4'd1) && (target_month_q <= 4'd12)
			&& (occurrence_q != 3'd0);
	end

	always_ff @(posedge clk) begin
		if (valid_s3) begin
			year_s4  <= year_s3;
			first_s4 <= first_day;
			len_s4   <= mlen;
			ok_s4    <= cfg_ok;
		end
	end

	// stage 5: n-th occurrence date against month end
	logic [5:0] weeks, date;
	logic       hit;

	assign weeks = (6'(occurrence_q - 3'd1) << 3) - 6'(occurrence_q - 3'd1);
	assign date  = 6'(first_s4) + weeks;
	assign hit   = ok_s4 && (date <= 6'(len_s4));

	always_ff @(posedge clk) begin
		if (valid_s4) begin
			result_year  <= year_s4;
			day_of_month <= hit ? date[4:0] : 5'd0;
			not_found    <= !hit;
		end
	end

endmodule

`default_nettype wire
